@@ sv/pulse_frequency_duty_thermometer_macros.svh @@
// Assertion helpers for the thermometer block.
`ifndef PULSE_FREQUENCY_DUTY_THERMOMETER_MACROS_SVH
`define PULSE_FREQUENCY_DUTY_THERMOMETER_MACROS_SVH

`ifndef SYNTHESIS
`define PFDT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfdt: property failed");
`define PFDT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pfdt: forbidden condition seen");
`else
`define PFDT_ASSERT(label, clk, rst, prop)
`define PFDT_NEVER(label, clk, rst, cond)
`endif

`endif

@@ sv/pfdt_pkg.sv @@
package pfdt_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int CNT_W       = 16;
  localparam int PERIOD_W    = 10;
  localparam int SUM_W       = 27;
  localparam int DIV_W       = 32;
  localparam int DUTY_W      = 14;
  localparam int AVG_W       = 27;
  localparam int FREQ_W      = 26;
  localparam int TEMP_W      = 22;
  localparam int BAND_W      = 3;
  localparam int THRESH_W    = 10;
  localparam int REM_W       = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 1'd1;

  localparam logic [CNT_W-1:0]    WINDOW_RESET = 16'd5000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd50;

  localparam int DUTY_SCALE = 10000;
  localparam int FREQ_NUM   = 100000000;
  localparam int TEMP_NUM   = 1000000;

  localparam logic [BAND_W-1:0] BAND_FIRST = 3'd0;
  localparam logic [BAND_W-1:0] BAND_LAST  = 3'd5;

  // One finished window, handed from the front to the back.
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] high;
    logic [CNT_W-1:0] total;
    logic [SUM_W-1:0] sum;
    logic [DIV_W-1:0] divisor;
  } pfdt_snap_t;

  typedef struct packed {
    logic       valid;
    pfdt_snap_t snap;
  } pfdt_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pfdt_qstat_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } pfdt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } pfdt_div_rsp_t;

  // Upper frequency edge of each band, in Hz.
  function automatic logic [THRESH_W-1:0] band_thresh(input logic [BAND_W-1:0] b);
    logic [THRESH_W-1:0] t;
    case (b)
      3'd0:    t = 10'd115;
      3'd1:    t = 10'd180;
      3'd2:    t = 10'd260;
      3'd3:    t = 10'd440;
      default: t = 10'd655;
    endcase
    return t;
  endfunction

  // Slope in thousandths times one million.
  function automatic logic [DIV_W-1:0] band_coef_num(input logic [BAND_W-1:0] b);
    logic [DIV_W-1:0] c;
    case (b)
      3'd0:    c = 32'd300000000;
      3'd1:    c = 32'd100000000;
      3'd2:    c = 32'd90000000;
      3'd3:    c = 32'd70000000;
      3'd4:    c = 32'd40000000;
      default: c = 32'd30000000;
    endcase
    return c;
  endfunction

  // The offset in thousandths is split as 10 * base + rem with rem in 0..9, so the
  // division that remains has a nonnegative numerator.
  function automatic logic [REM_W-1:0] band_rem(input logic [BAND_W-1:0] b);
    logic [REM_W-1:0] r;
    case (b)
      3'd2:    r = 4'd1;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [TEMP_W-1:0] band_base(input logic [BAND_W-1:0] b);
    logic signed [TEMP_W-1:0] v;
    case (b)
      3'd0:    v = -22'sd1990;
      3'd1:    v = 22'sd55;
      3'd2:    v = 22'sd423;
      3'd3:    v = 22'sd1028;
      3'd4:    v = 22'sd2021;
      default: v = 22'sd2633;
    endcase
    return v;
  endfunction

endpackage

@@ sv/pfdt_if.sv @@
interface pfdt_sample_if ();
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface pfdt_result_if import pfdt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     measure_ok;
  logic [DUTY_W-1:0]        duty_centi_pct;
  logic [AVG_W-1:0]         avg_period_us;
  logic [FREQ_W-1:0]        freq_centi_hz;
  logic signed [TEMP_W-1:0] temp_centi_deg;
  logic [BAND_W-1:0]        fit_band;

  modport source (
    output valid, output measure_ok, output duty_centi_pct, output avg_period_us,
    output freq_centi_hz, output temp_centi_deg, output fit_band, input ready
  );
  modport sink (
    input valid, input measure_ok, input duty_centi_pct, input avg_period_us,
    input freq_centi_hz, input temp_centi_deg, input fit_band, output ready
  );
endinterface

@@ sv/pfdt_front.sv @@
module pfdt_front import pfdt_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    window_samples,
  input  logic [PERIOD_W-1:0] sample_period_us,
  pfdt_sample_if.sink         sample,
  input  pfdt_qstat_t         q_stat,
  output pfdt_push_t          q_push
);

  logic [CNT_W-1:0]      sample_counter, sample_counter_next;
  logic [CNT_W-1:0]      high_count, high_count_next;
  logic                  have_level, have_level_next;
  logic                  run_level, run_level_next;
  logic [COUNT_BITS-1:0] run_length, run_length_next;
  logic [COUNT_BITS-1:0] runs_done, runs_done_next;
  logic [COUNT_BITS-1:0] prev_run, prev_run_next;
  logic [COUNT_BITS-1:0] prev_prev_run, prev_prev_run_next;
  logic [SUM_W-1:0]      period_sum_us, period_sum_us_next;

  logic [CNT_W-1:0]              win_eff;
  logic [PERIOD_W-1:0]           per_eff;
  logic [COUNT_BITS:0]           pair;
  logic [COUNT_BITS+PERIOD_W:0]  pair_time;
  logic                          accept;
  logic                          window_done;

  assign sample.ready = !q_stat.full;
  assign accept       = sample.valid && sample.ready;

  assign win_eff   = (window_samples == '0) ? CNT_W'(1) : window_samples;
  assign per_eff   = (sample_period_us == '0) ? PERIOD_W'(1) : sample_period_us;
  assign pair      = {1'b0, prev_prev_run} + {1'b0, prev_run};
  assign pair_time = pair * per_eff;

  always_comb begin
    high_count_next    = high_count + CNT_W'(sample.level);
    have_level_next    = 1'b1;
    run_level_next     = run_level;
    run_length_next    = run_length;
    runs_done_next     = runs_done;
    prev_run_next      = prev_run;
    prev_prev_run_next = prev_prev_run;
    period_sum_us_next = period_sum_us;

    if (!have_level) begin
      run_level_next  = sample.level;
      run_length_next = COUNT_BITS'(1);
    end else if (sample.level == run_level) begin
      run_length_next = (run_length == '1) ? run_length : run_length + COUNT_BITS'(1);
    end else begin
      // A run just closed: the two runs before it form one full period.
      if (runs_done >= COUNT_BITS'(2)) begin
        period_sum_us_next = period_sum_us + SUM_W'(pair_time);
      end
      prev_prev_run_next = prev_run;
      prev_run_next      = run_length;
      runs_done_next     = (runs_done == '1) ? runs_done : runs_done + COUNT_BITS'(1);
      run_level_next     = sample.level;
      run_length_next    = COUNT_BITS'(1);
    end

    sample_counter_next = sample_counter + CNT_W'(1);
    window_done         = (sample_counter_next >= win_eff);

    q_push.valid        = accept && window_done;
    q_push.snap.ok      = (runs_done_next >= COUNT_BITS'(3));
    q_push.snap.high    = high_count_next;
    q_push.snap.total   = sample_counter_next;
    q_push.snap.sum     = period_sum_us_next;
    q_push.snap.divisor = DIV_W'(runs_done_next - COUNT_BITS'(2));
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && window_done)) begin
      sample_counter <= '0;
      high_count     <= '0;
      have_level     <= 1'b0;
      run_level      <= 1'b0;
      run_length     <= '0;
      runs_done      <= '0;
      prev_run       <= '0;
      prev_prev_run  <= '0;
      period_sum_us  <= '0;
    end else if (accept) begin
      sample_counter <= sample_counter_next;
      high_count     <= high_count_next;
      have_level     <= have_level_next;
      run_level      <= run_level_next;
      run_length     <= run_length_next;
      runs_done      <= runs_done_next;
      prev_run       <= prev_run_next;
      prev_prev_run  <= prev_prev_run_next;
      period_sum_us  <= period_sum_us_next;
    end
  end

endmodule

@@ sv/pfdt_queue.sv @@
module pfdt_queue import pfdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pfdt_push_t  q_push,
  input  logic        pop,
  output pfdt_snap_t  head,
  output pfdt_qstat_t q_stat
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  pfdt_snap_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (count == COUNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  assign do_push = q_push.valid && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

endmodule

@@ sv/pfdt_div.sv @@
module pfdt_div import pfdt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  pfdt_div_req_t req,
  output pfdt_div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  den;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = (rem_sh >= {1'b0, den});

  assign rsp.done = done;
  assign rsp.quo  = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/pfdt_back.sv @@
module pfdt_back import pfdt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  pfdt_snap_t    head,
  input  pfdt_qstat_t   q_stat,
  output logic          pop,
  output pfdt_div_req_t div_req,
  input  pfdt_div_rsp_t div_rsp,
  pfdt_result_if.source result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DUTY = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_FREQ = 3'd3;
  localparam logic [2:0] S_BAND = 3'd4;
  localparam logic [2:0] S_TEMP = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int PROD_W = AVG_W + THRESH_W;

  logic [2:0]               state, state_next;
  pfdt_snap_t               snap;
  logic [DUTY_W-1:0]        duty;
  logic [AVG_W-1:0]         avg;
  logic [FREQ_W-1:0]        freq;
  logic signed [TEMP_W-1:0] temp;
  logic [BAND_W-1:0]        band;

  logic [AVG_W-1:0]  avg_quo;
  logic [PROD_W-1:0] band_prod;
  logic              band_stop;

  // Every period spans at least two samples, so a zero mean never shows up in
  // practice; it is still kept off the frequency divider.
  assign avg_quo   = (div_rsp.quo == '0) ? AVG_W'(1) : div_rsp.quo[AVG_W-1:0];
  assign band_prod = PROD_W'(band_thresh(band)) * PROD_W'(avg);

  always_comb begin
    if (band == BAND_LAST) begin
      band_stop = 1'b1;
    end else if (band == BAND_FIRST) begin
      band_stop = (PROD_W'(TEMP_NUM) < band_prod);
    end else begin
      band_stop = (PROD_W'(TEMP_NUM) <= band_prod);
    end
  end

  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop           = 1'b1;
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(head.high) * DIV_W'(DUTY_SCALE);
          div_req.den   = DIV_W'(head.total);
          state_next    = S_DUTY;
        end
      end
      S_DUTY: begin
        if (div_rsp.done) begin
          if (snap.ok) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(snap.sum);
            div_req.den   = snap.divisor;
            state_next    = S_AVG;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_AVG: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(FREQ_NUM);
          div_req.den   = DIV_W'(avg_quo);
          state_next    = S_FREQ;
        end
      end
      S_FREQ: begin
        if (div_rsp.done) begin
          state_next = S_BAND;
        end
      end
      S_BAND: begin
        if (band_stop) begin
          div_req.start = 1'b1;
          div_req.num   = band_coef_num(band) + DIV_W'(band_rem(band)) * DIV_W'(avg);
          div_req.den   = (DIV_W'(avg) << 3) + (DIV_W'(avg) << 1);
          state_next    = S_TEMP;
        end
      end
      S_TEMP: begin
        if (div_rsp.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        snap <= head;
        avg  <= '0;
        freq <= '0;
        temp <= '0;
        band <= BAND_FIRST;
      end
      S_DUTY: begin
        if (div_rsp.done) begin
          duty <= div_rsp.quo[DUTY_W-1:0];
        end
      end
      S_AVG: begin
        if (div_rsp.done) begin
          avg <= avg_quo;
        end
      end
      S_FREQ: begin
        if (div_rsp.done) begin
          freq <= div_rsp.quo[FREQ_W-1:0];
        end
      end
      S_BAND: begin
        if (!band_stop) begin
          band <= band + BAND_W'(1);
        end
      end
      S_TEMP: begin
        if (div_rsp.done) begin
          temp <= band_base(band) + $signed(div_rsp.quo[TEMP_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid          = (state == S_OUT);
  assign result.measure_ok     = snap.ok;
  assign result.duty_centi_pct = duty;
  assign result.avg_period_us  = avg;
  assign result.freq_centi_hz  = freq;
  assign result.temp_centi_deg = temp;
  assign result.fit_band       = band;

endmodule

@@ sv/pulse_frequency_duty_thermometer.sv @@
// Pulse frequency and duty-cycle thermometer. The block takes one sampled pin
// level per transfer on the sample channel and, once every window_samples
// samples, delivers one result transfer carrying duty cycle, mean period,
// frequency, and a six-band fitted temperature with its band. The front end
// takes one sample per clock cycle whenever its two-entry window queue has room;
// a finished window does not stall it. The back end works through each
// window on one shared radix-2 divider (four divisions when the window saw at
// least three completed runs, one otherwise) plus a band search when it has
// enough runs, and the sample channel stalls only while the window queue is
// full. Registers: index 0 is window_samples, index 1 is sample_period_us;
// write them only while the block is idle.
`include "pulse_frequency_duty_thermometer_macros.svh"

module pulse_frequency_duty_thermometer import pfdt_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pfdt_sample_if.sink            sample,
  pfdt_result_if.source          result
);

  logic [CNT_W-1:0]    window_samples;
  logic [PERIOD_W-1:0] sample_period_us;

  pfdt_push_t    q_push;
  pfdt_qstat_t   q_stat;
  pfdt_snap_t    head;
  logic          pop;
  pfdt_div_req_t div_req;
  pfdt_div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples   <= WINDOW_RESET;
      sample_period_us <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW: window_samples   <= cfg_data[CNT_W-1:0];
        REG_PERIOD: sample_period_us <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pfdt_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .window_samples   (window_samples),
    .sample_period_us (sample_period_us),
    .sample           (sample),
    .q_stat           (q_stat),
    .q_push           (q_push)
  );

  pfdt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  pfdt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pfdt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .result  (result)
  );

  `PFDT_NEVER(a_queue_overflow, clk, rst, q_push.valid && q_stat.full)
  `PFDT_ASSERT(a_no_measure_zero, clk, rst, (result.valid && !result.measure_ok) |-> (result.avg_period_us == '0 && result.freq_centi_hz == '0 && result.fit_band == BAND_FIRST))
  `PFDT_ASSERT(a_band_range, clk, rst, result.valid |-> (result.fit_band <= BAND_LAST))
  `PFDT_ASSERT(a_duty_range, clk, rst, result.valid |-> (result.duty_centi_pct <= DUTY_W'(DUTY_SCALE)))

endmodule

@@ verif/pulse_frequency_duty_thermometer_tb.sv @@
module pulse_frequency_duty_thermometer_tb;
  import pfdt_pkg::*;

  localparam int unsigned RUN_CAP       = (1 << COUNT_BITS_DEFAULT) - 1;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          IDLE_LIMIT    = 20000;
  localparam int          HOLD_OFF      = 1500;
  localparam int          RANDOM_ITEMS  = 600;

  // Band upper edges in Hz, fit slope and offset in thousandths.
  localparam longint BAND_EDGE_HZ [5] = '{115, 180, 260, 440, 655};
  localparam longint SLOPE_MILLI  [6] = '{300, 100, 90, 70, 40, 30};
  localparam longint OFFSET_MILLI [6] = '{-19900, 550, 4231, 10280, 20210, 26330};

  typedef struct {
    logic                     ok;
    logic [DUTY_W-1:0]        duty;
    logic [AVG_W-1:0]         avg;
    logic [FREQ_W-1:0]        freq;
    logic signed [TEMP_W-1:0] temp;
    logic [BAND_W-1:0]        band;
  } window_report_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pfdt_sample_if sample_ch ();
  pfdt_result_if result_ch ();

  pulse_frequency_duty_thermometer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  logic           level_backlog [$];
  window_report_t pending_reports [$];

  // Register copies and window state of the predictor.
  int unsigned     window_setting = WINDOW_RESET;
  int unsigned     period_setting = PERIOD_RESET;
  int unsigned     win_count, high_cnt, cur_run, runs_closed, last_run, last_run2;
  bit              seen_level, cur_level;
  longint unsigned period_acc;

  int  mismatches   = 0;
  int  results_seen = 0;
  bit  stress_go    = 1'b0;
  bit  stress_done  = 1'b0;
  int  burst_left, gap_left;
  int  hold_left, mode_left, rx_tick, idle_cycles;
  int  ready_mode;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic clear_window();
    win_count   = 0;
    high_cnt    = 0;
    seen_level  = 1'b0;
    cur_level   = 1'b0;
    cur_run     = 0;
    runs_closed = 0;
    last_run    = 0;
    last_run2   = 0;
    period_acc  = 0;
  endtask

  task automatic advance_window(input logic lvl);
    longint         win, per, avg, num, den, temp, duty, freq;
    int             band;
    window_report_t rep;
    win = (window_setting == 0) ? 1 : window_setting;
    per = (period_setting == 0) ? 1 : period_setting;
    if (lvl) high_cnt++;
    if (!seen_level) begin
      seen_level = 1'b1;
      cur_level  = lvl;
      cur_run    = 1;
    end else if (lvl == cur_level) begin
      if (cur_run < RUN_CAP) cur_run++;
    end else begin
      if (runs_closed >= 2) period_acc += (longint'(last_run2) + last_run) * per;
      last_run2 = last_run;
      last_run  = cur_run;
      if (runs_closed < RUN_CAP) runs_closed++;
      cur_level = lvl;
      cur_run   = 1;
    end
    win_count++;
    if (win_count < win) return;

    duty = longint'(high_cnt) * 10000 / win_count;
    avg  = 0;
    freq = 0;
    temp = 0;
    band = 0;
    if (runs_closed >= 3) begin
      avg = period_acc / (runs_closed - 2);
      if (avg == 0) avg = 1;
      freq = 100000000 / avg;
      if (1000000 < BAND_EDGE_HZ[0] * avg) begin
        band = 0;
      end else begin
        band = 5;
        for (int b = 4; b >= 1; b--) begin
          if (1000000 <= BAND_EDGE_HZ[b] * avg) band = b;
        end
      end
      num  = SLOPE_MILLI[band] * 1000000 + OFFSET_MILLI[band] * avg;
      den  = 10 * avg;
      temp = (num >= 0) ? num / den : -((-num + den - 1) / den);
    end
    rep.ok   = (runs_closed >= 3);
    rep.duty = duty[DUTY_W-1:0];
    rep.avg  = avg[AVG_W-1:0];
    rep.freq = freq[FREQ_W-1:0];
    rep.temp = temp[TEMP_W-1:0];
    rep.band = band[BAND_W-1:0];
    pending_reports.push_back(rep);
    clear_window();
  endtask

  // Sample driver: bursts of random length with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        advance_window(sample_ch.level);
        void'(level_backlog.pop_front());
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left != 0) begin
          gap_left        <= gap_left - 1;
          sample_ch.valid <= 1'b0;
        end else if (level_backlog.size() != 0) begin
          sample_ch.valid <= 1'b1;
          sample_ch.level <= level_backlog[0];
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 48);
            if ($urandom_range(0, 3) != 0) gap_left <= 0;
            else if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(10, 30);
            else gap_left <= $urandom_range(1, 4);
          end
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: a changing stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
      mode_left       <= 0;
      ready_mode      <= 0;
      rx_tick         <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (stress_go && !stress_done) begin
        stress_done     <= 1'b1;
        hold_left       <= HOLD_OFF;
        result_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        result_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(16, 128);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (ready_mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom_range(0, 1));
          2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
          default: result_ch.ready <= (rx_tick % 8 > 2);
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    window_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result transfer with no window pending");
      end else begin
        want = pending_reports.pop_front();
        if (result_ch.measure_ok !== want.ok || result_ch.duty_centi_pct !== want.duty ||
            result_ch.avg_period_us !== want.avg || result_ch.freq_centi_hz !== want.freq ||
            result_ch.temp_centi_deg !== want.temp || result_ch.fit_band !== want.band) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: exp ok=%0d duty=%0d avg=%0d freq=%0d temp=%0d band=%0d",
                     want.ok, want.duty, want.avg, want.freq, want.temp, want.band);
            $display("       got ok=%0d duty=%0d avg=%0d freq=%0d temp=%0d band=%0d",
                     result_ch.measure_ok, result_ch.duty_centi_pct, result_ch.avg_period_us,
                     result_ch.freq_centi_hz, result_ch.temp_centi_deg, result_ch.fit_band);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW) window_setting = val;
    else period_setting = val & 16'h03FF;
  endtask

  task automatic push_bits(input logic [31:0] bits, input int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) level_backlog.push_back(bits[i]);
  endtask

  // Square wave with the given run lengths, optional jitter and random noise.
  task automatic push_levels(input int count, input int hi_len, input int lo_len,
                             input bit jitter, input int noise_pct);
    logic lvl;
    int   left;
    lvl  = 1'($urandom_range(0, 1));
    left = $urandom_range(1, lvl ? hi_len : lo_len);
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1, 100) <= noise_pct) level_backlog.push_back(1'($urandom_range(0, 1)));
      else level_backlog.push_back(lvl);
      if (left <= 1) begin
        lvl  = ~lvl;
        left = lvl ? hi_len : lo_len;
        if (jitter && $urandom_range(0, 3) == 0) left += $urandom_range(0, 3);
      end else begin
        left--;
      end
    end
  endtask

  // Sender pause: every queued sample and every pending window has gone through.
  task automatic drain();
    while (level_backlog.size() != 0 || pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_items, results_mark, win, nwin, pick;
    clear_window();
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_WINDOW;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero window and zero period both act as one.
    write_reg(REG_WINDOW, 16'd0);
    write_reg(REG_PERIOD, 16'd0);
    push_bits(32'b01, 2);
    drain();
    // Alternating levels, sample period of 1000 us.
    write_reg(REG_WINDOW, 16'd8);
    write_reg(REG_PERIOD, 16'd1000);
    push_bits(32'b01010101, 8);
    drain();
    // Too few runs for a period.
    write_reg(REG_WINDOW, 16'd3);
    push_bits(32'b111, 3);
    drain();
    // Window shrunk below the samples already taken.
    write_reg(REG_WINDOW, 16'd10);
    write_reg(REG_PERIOD, 16'd7);
    push_bits(32'b001100, 6);
    drain();
    write_reg(REG_WINDOW, 16'd2);
    push_bits(32'b1, 1);
    drain();
    // Upper bits of the period write are dropped.
    write_reg(REG_WINDOW, 16'd6);
    write_reg(REG_PERIOD, 16'hFFFF);
    push_bits(32'b101010, 6);
    drain();

    // Short windows while the result side holds off, so the input backs up.
    results_mark = results_seen;
    random_items = 0;
    write_reg(REG_WINDOW, 16'd4);
    write_reg(REG_PERIOD, 16'($urandom_range(1, 1000)));
    stress_go <= 1'b1;
    push_levels(200, 2, 3, 1'b1, 0);
    random_items += 200;
    drain();

    while (random_items < RANDOM_ITEMS || results_seen < results_mark + 40) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) win = 1;
      else if (pick == 1) win = $urandom_range(60, 150);
      else win = $urandom_range(2, 40);
      nwin = $urandom_range(1, 4) + ((win <= 40) ? $urandom_range(2, 6) : 0);
      write_reg(REG_WINDOW, 16'(win));
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(REG_PERIOD, 16'd1);
      else if (pick == 1) write_reg(REG_PERIOD, 16'd1000);
      else if (pick == 2) write_reg(REG_PERIOD, 16'd0);
      else write_reg(REG_PERIOD, 16'($urandom_range(1, 1000)));
      pick = $urandom_range(0, 19);
      if (pick < 12) push_levels(win * nwin, $urandom_range(1, 12), $urandom_range(1, 12),
                                 1'($urandom_range(0, 1)), 0);
      else if (pick < 15) push_levels(win * nwin, 1, 1, 1'b0, 0);
      else if (pick < 18) push_levels(win * nwin, 1, 1, 1'b0, 100);
      else if (pick == 18) push_levels(win * nwin, RUN_CAP, RUN_CAP, 1'b0, 0);
      else push_levels(win * nwin, $urandom_range(2, 8), $urandom_range(2, 8), 1'b1, 10);
      random_items += win * nwin;
      drain();
    end

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
